### hdl/cgn_pkg.sv
// ----------------------------------------------------------------------------
// Grid cell store package
// Shared widths, codes, types and step tables for the grid cell store.
// ----------------------------------------------------------------------------
`default_nettype none

package cgn_pkg;

    localparam int SIDE_W   = 6;
    localparam int DIM_W    = 7;
    localparam int IDX_W    = 12;
    localparam int CELLS    = 4096;
    localparam int FLAG_W   = 8;
    localparam int COST_W   = 16;
    localparam int BLOCKED_BIT = 0;
    localparam int MAX_SIDE = 64;
    localparam logic [COST_W-1:0] COST_MAX = '1;
    localparam logic [COST_W-1:0] COST_ONE = 16'd256;

    localparam logic [2:0] OP_READ        = 3'd0;
    localparam logic [2:0] OP_SET_COST    = 3'd1;
    localparam logic [2:0] OP_SET_FLAGS   = 3'd2;
    localparam logic [2:0] OP_SET_BLOCKED = 3'd3;
    localparam logic [2:0] OP_FILL        = 3'd4;
    localparam logic [2:0] OP_CLEAR       = 3'd5;
    localparam logic [2:0] OP_NEIGHBOURS  = 3'd6;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DIAG   = 2'd2;
    localparam logic [1:0] CFG_CUT    = 2'd3;

    localparam logic [2:0] DIR_N  = 3'd0;
    localparam logic [2:0] DIR_E  = 3'd1;
    localparam logic [2:0] DIR_S  = 3'd2;
    localparam logic [2:0] DIR_W  = 3'd3;
    localparam logic [2:0] DIR_NE = 3'd4;
    localparam logic [2:0] DIR_SE = 3'd5;
    localparam logic [2:0] DIR_SW = 3'd6;
    localparam logic [2:0] DIR_NW = 3'd7;

    typedef enum logic [2:0] {
        K_CELL  = 3'd0,
        K_FILL  = 3'd1,
        K_CLEAR = 3'd2,
        K_NBR   = 3'd3,
        K_NOP   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [2:0]              op;
        logic signed [7:0]       x;
        logic signed [7:0]       y;
        logic [DIM_W-1:0]        rw;
        logic [DIM_W-1:0]        rh;
        logic [FLAG_W-1:0]       flags;
        logic [COST_W-1:0]       cost;
        logic                    blocked;
    } t_item;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             diag;
        logic             cut;
    } t_cfg;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } t_back_ctl;

    typedef struct packed {
        logic              in_bounds;
        logic              walkable;
        logic [FLAG_W-1:0] flags;
        logic [COST_W-1:0] cost;
        logic              nb_valid;
        logic [SIDE_W-1:0] nb_x;
        logic [SIDE_W-1:0] nb_y;
        logic [2:0]        dir;
        logic              last;
    } t_result;

    function automatic logic signed [1:0] step_dx(input logic [2:0] d);
        logic signed [1:0] r;
        case (d)
            DIR_N:   r = 2'sd0;
            DIR_E:   r = 2'sd1;
            DIR_S:   r = 2'sd0;
            DIR_W:   r = -2'sd1;
            DIR_NE:  r = 2'sd1;
            DIR_SE:  r = 2'sd1;
            DIR_SW:  r = -2'sd1;
            default: r = -2'sd1;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] step_dy(input logic [2:0] d);
        logic signed [1:0] r;
        case (d)
            DIR_N:   r = -2'sd1;
            DIR_E:   r = 2'sd0;
            DIR_S:   r = 2'sd1;
            DIR_W:   r = 2'sd0;
            DIR_NE:  r = -2'sd1;
            DIR_SE:  r = 2'sd1;
            DIR_SW:  r = 2'sd1;
            default: r = -2'sd1;
        endcase
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_side(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_SIDE)) begin
            r = DIM_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/grid_cell_store_neighbor_query_core.sv
// A neighbour query returns its results one per cycle while the output is not stalled; a
// fill writes each cell of the clipped rectangle and a clear writes each cell of the grid.
// The back end carries out one operation at a time and takes the next from the two-entry
// queue once it is idle again. Reset: a clearing pass over every cell of the memory sets
// it to cost 1.0 and no flags; no input transaction is taken until the pass ends.
// ----------------------------------------------------------------------------
// Grid cell store with neighbour query
// Top level: configuration registers, front end queue and back end sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_cell_store_neighbor_query_core import cgn_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [DIM_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [2:0]              i_op,
    input  logic signed [7:0]       i_x,
    input  logic signed [7:0]       i_y,
    input  logic [DIM_W-1:0]        i_rect_width,
    input  logic [DIM_W-1:0]        i_rect_height,
    input  logic [FLAG_W-1:0]       i_flags_in,
    input  logic [COST_W-1:0]       i_cost_in,
    input  logic                    i_blocked_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_in_bounds,
    output logic                    o_walkable,
    output logic [FLAG_W-1:0]       o_cell_flags,
    output logic [COST_W-1:0]       o_cell_cost,
    output logic                    o_neighbour_valid,
    output logic [SIDE_W-1:0]       o_neighbour_x,
    output logic [SIDE_W-1:0]       o_neighbour_y,
    output logic [2:0]              o_direction,
    output logic                    o_last
);

    t_cfg      r_cfg;
    t_back_ctl w_ctl;
    logic      w_q_valid;
    t_item     w_q_item;
    t_result   w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= DIM_W'(10);
            r_cfg.height <= DIM_W'(10);
            r_cfg.diag   <= 1'b1;
            r_cfg.cut    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_cfg.width  <= clamp_side(i_cfg_data);
                CFG_HEIGHT: r_cfg.height <= clamp_side(i_cfg_data);
                CFG_DIAG:   r_cfg.diag   <= i_cfg_data[0];
                CFG_CUT:    r_cfg.cut    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    cgn_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_flags_in    (i_flags_in),
        .i_cost_in     (i_cost_in),
        .i_blocked_in  (i_blocked_in),
        .i_ctl         (w_ctl),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item)
    );

    cgn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_ctl       (w_ctl),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (w_res)
    );

    assign o_in_bounds       = w_res.in_bounds;
    assign o_walkable        = w_res.walkable;
    assign o_cell_flags      = w_res.flags;
    assign o_cell_cost       = w_res.cost;
    assign o_neighbour_valid = w_res.nb_valid;
    assign o_neighbour_x     = w_res.nb_x;
    assign o_neighbour_y     = w_res.nb_y;
    assign o_direction       = w_res.dir;
    assign o_last            = w_res.last;

endmodule

`default_nettype wire

### hdl/cgn_front.sv
// ----------------------------------------------------------------------------
// Grid cell store front end
// Accepts operations, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cgn_front import cgn_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [2:0]              i_op,
    input  logic signed [7:0]       i_x,
    input  logic signed [7:0]       i_y,
    input  logic [DIM_W-1:0]        i_rect_width,
    input  logic [DIM_W-1:0]        i_rect_height,
    input  logic [FLAG_W-1:0]       i_flags_in,
    input  logic [COST_W-1:0]       i_cost_in,
    input  logic                    i_blocked_in,
    input  t_back_ctl               i_ctl,
    output logic                    o_q_valid,
    output t_item                   o_q_item
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_item.op      = i_op;
        w_item.x       = i_x;
        w_item.y       = i_y;
        w_item.rw      = i_rect_width;
        w_item.rh      = i_rect_height;
        w_item.flags   = i_flags_in;
        w_item.cost    = i_cost_in;
        w_item.blocked = i_blocked_in;
        case (i_op)
            OP_READ, OP_SET_COST, OP_SET_FLAGS, OP_SET_BLOCKED: w_item.kind = K_CELL;
            OP_FILL:       w_item.kind = K_FILL;
            OP_CLEAR:      w_item.kind = K_CLEAR;
            OP_NEIGHBOURS: w_item.kind = K_NBR;
            default:       w_item.kind = K_NOP;
        endcase
    end

    assign o_in_ready = (r_cnt != 2'd2) && !i_ctl.init_busy;
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_ctl.pop && o_q_valid;
    assign o_q_valid  = r_cnt != 2'd0;
    assign o_q_item   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

`default_nettype wire

### hdl/cgn_back.sv
// ----------------------------------------------------------------------------
// Grid cell store back end
// Holds the cell memory and carries out queued operations one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cgn_back import cgn_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_item   i_q_item,
    output t_back_ctl o_ctl,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    typedef enum logic [9:0] {
        ST_INIT    = 10'b0000000001,
        ST_IDLE    = 10'b0000000010,
        ST_CELL_DO = 10'b0000000100,
        ST_FILL    = 10'b0000001000,
        ST_CLEAR   = 10'b0000010000,
        ST_NB_RD   = 10'b0000100000,
        ST_NB_LAST = 10'b0001000000,
        ST_NB_MASK = 10'b0010000000,
        ST_NB_EMIT = 10'b0100000000,
        ST_EMIT    = 10'b1000000000
    } t_state;

    localparam int WORD_W = FLAG_W + COST_W;

    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    logic [IDX_W:0]      r_cnt;
    logic [IDX_W-1:0]    r_addr;
    logic [DIM_W-1:0]    r_cx;
    logic [DIM_W-1:0]    r_cy;
    logic [DIM_W-1:0]    r_x0;
    logic [DIM_W-1:0]    r_x1;
    logic [DIM_W-1:0]    r_y1;
    logic [2:0]          r_d;
    logic                r_dly_v;
    logic [2:0]          r_dly_d;
    logic [7:0]          r_nb_inb;
    logic [WORD_W-1:0]   r_nb_data [8];
    logic [7:0]          r_ok;
    t_result             r_pend;
    t_result             r_out;
    logic                r_ov;

    logic [WORD_W-1:0]   r_mem [CELLS];
    logic [WORD_W-1:0]   r_rdata;
    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic [WORD_W-1:0]   w_wdata;

    logic [SIDE_W-1:0]   w_ax;
    logic [SIDE_W-1:0]   w_ay;
    logic [IDX_W:0]      w_prod;
    logic [IDX_W-1:0]    w_idx;
    logic signed [8:0]   w_nbx;
    logic signed [8:0]   w_nby;
    logic                w_nb_inb;
    logic                w_q_inb;
    logic [DIM_W-1:0]    w_fx0;
    logic [DIM_W-1:0]    w_fy0;
    logic [DIM_W-1:0]    w_fx1;
    logic [DIM_W-1:0]    w_fy1;
    logic signed [8:0]   w_fxe;
    logic signed [8:0]   w_fye;
    logic                w_fempty;
    logic [IDX_W:0]      w_area;
    logic [FLAG_W-1:0]   w_nfl;
    logic [COST_W-1:0]   w_nco;
    logic [7:0]          w_walk;
    logic [7:0]          w_okc;
    logic [2:0]          w_sel;
    logic [7:0]          w_rest;
    logic                w_free;
    logic                w_ld;
    t_result             w_ld_res;
    t_result             w_ack;
    t_result             w_oob;
    t_result             w_cell_res;
    t_result             w_nb_res;

    // Address generation: one multiply for the row-major index.
    always_comb begin
        w_nbx = 9'(r_item.x) + 9'(step_dx(r_d));
        w_nby = 9'(r_item.y) + 9'(step_dy(r_d));
        w_nb_inb = (w_nbx >= 0) && (w_nby >= 0)
                && (w_nbx < $signed({2'b00, i_cfg.width}))
                && (w_nby < $signed({2'b00, i_cfg.height}));
        w_q_inb = !i_q_item.x[7] && !i_q_item.y[7]
               && (i_q_item.x[6:0] < i_cfg.width) && (i_q_item.y[6:0] < i_cfg.height);
        case (r_state)
            ST_IDLE: begin
                w_ax = i_q_item.x[SIDE_W-1:0];
                w_ay = i_q_item.y[SIDE_W-1:0];
            end
            ST_NB_RD: begin
                w_ax = w_nbx[SIDE_W-1:0];
                w_ay = w_nby[SIDE_W-1:0];
            end
            ST_FILL: begin
                w_ax = r_cx[SIDE_W-1:0];
                w_ay = r_cy[SIDE_W-1:0];
            end
            default: begin
                w_ax = '0;
                w_ay = '0;
            end
        endcase
        w_prod = w_ay * i_cfg.width;
        w_idx  = w_prod[IDX_W-1:0] + IDX_W'(w_ax);
    end

    // Rectangle clipping for a fill at the head of the queue.
    always_comb begin
        w_fx0 = i_q_item.x[7] ? '0 : i_q_item.x[6:0];
        w_fy0 = i_q_item.y[7] ? '0 : i_q_item.y[6:0];
        w_fxe = 9'(i_q_item.x) + $signed({2'b00, i_q_item.rw});
        w_fye = 9'(i_q_item.y) + $signed({2'b00, i_q_item.rh});
        if (w_fxe <= 0) begin
            w_fx1 = '0;
        end else if (w_fxe > $signed({2'b00, i_cfg.width})) begin
            w_fx1 = i_cfg.width;
        end else begin
            w_fx1 = w_fxe[DIM_W-1:0];
        end
        if (w_fye <= 0) begin
            w_fy1 = '0;
        end else if (w_fye > $signed({2'b00, i_cfg.height})) begin
            w_fy1 = i_cfg.height;
        end else begin
            w_fy1 = w_fye[DIM_W-1:0];
        end
        w_fempty = (w_fx1 <= w_fx0) || (w_fy1 <= w_fy0);
        w_area   = i_cfg.width * i_cfg.height;
    end

    // Single-cell update.
    always_comb begin
        w_nfl = r_rdata[WORD_W-1:COST_W];
        w_nco = r_rdata[COST_W-1:0];
        case (r_item.op)
            OP_SET_COST:    w_nco = r_item.cost;
            OP_SET_FLAGS:   w_nfl = r_item.flags;
            OP_SET_BLOCKED: w_nfl[BLOCKED_BIT] = r_item.blocked;
            default: ;
        endcase
        w_ack      = '0;
        w_ack.last = 1'b1;
        w_oob      = '0;
        w_oob.cost = COST_MAX;
        w_oob.last = 1'b1;
        w_cell_res           = '0;
        w_cell_res.in_bounds = 1'b1;
        w_cell_res.walkable  = !w_nfl[BLOCKED_BIT];
        w_cell_res.flags     = w_nfl;
        w_cell_res.cost      = w_nco;
        w_cell_res.last      = 1'b1;
    end

    // Neighbour selection.
    always_comb begin
        for (int d = 0; d < 8; d++) begin
            w_walk[d] = r_nb_inb[d] && !r_nb_data[d][COST_W + BLOCKED_BIT];
        end
        w_okc[3:0] = w_walk[3:0];
        w_okc[DIR_NE] = i_cfg.diag && w_walk[DIR_NE]
                     && (i_cfg.cut || (w_walk[DIR_E] && w_walk[DIR_N]));
        w_okc[DIR_SE] = i_cfg.diag && w_walk[DIR_SE]
                     && (i_cfg.cut || (w_walk[DIR_E] && w_walk[DIR_S]));
        w_okc[DIR_SW] = i_cfg.diag && w_walk[DIR_SW]
                     && (i_cfg.cut || (w_walk[DIR_W] && w_walk[DIR_S]));
        w_okc[DIR_NW] = i_cfg.diag && w_walk[DIR_NW]
                     && (i_cfg.cut || (w_walk[DIR_W] && w_walk[DIR_N]));
        w_sel = '0;
        for (int d = 0; d < 8; d++) begin
            if (r_ok[d]) begin
                w_sel = 3'(d);
            end
        end
        w_rest = r_ok & ~(8'b1 << w_sel);
        w_nb_res           = '0;
        w_nb_res.in_bounds = 1'b1;
        w_nb_res.walkable  = 1'b1;
        w_nb_res.flags     = r_nb_data[w_sel][WORD_W-1:COST_W];
        w_nb_res.cost      = r_nb_data[w_sel][COST_W-1:0];
        w_nb_res.nb_valid  = 1'b1;
        w_nb_res.nb_x      = r_item.x[SIDE_W-1:0] + SIDE_W'(step_dx(w_sel));
        w_nb_res.nb_y      = r_item.y[SIDE_W-1:0] + SIDE_W'(step_dy(w_sel));
        w_nb_res.dir       = w_sel;
        w_nb_res.last      = w_rest == '0;
    end

    // Control.
    always_comb begin
        w_free   = !r_ov || i_res_ready;
        n_state  = r_state;
        w_ld     = 1'b0;
        w_ld_res = r_pend;
        w_we     = 1'b0;
        w_waddr  = r_cnt[IDX_W-1:0];
        w_wdata  = {{FLAG_W{1'b0}}, COST_ONE};
        o_ctl.pop       = 1'b0;
        o_ctl.init_busy = r_state == ST_INIT;
        case (r_state)
            ST_INIT: begin
                w_we = 1'b1;
                if (r_cnt[IDX_W-1:0] == IDX_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_ctl.pop = 1'b1;
                    case (i_q_item.kind)
                        K_CELL:  n_state = w_q_inb ? ST_CELL_DO : ST_EMIT;
                        K_FILL:  n_state = w_fempty ? ST_EMIT : ST_FILL;
                        K_CLEAR: n_state = ST_CLEAR;
                        K_NBR:   n_state = ST_NB_RD;
                        default: n_state = ST_EMIT;
                    endcase
                end
            end
            ST_CELL_DO: begin
                w_we    = r_item.op != OP_READ;
                w_waddr = r_addr;
                w_wdata = {w_nfl, w_nco};
                n_state = ST_EMIT;
            end
            ST_FILL: begin
                w_we    = 1'b1;
                w_waddr = w_idx;
                w_wdata = {r_item.flags, r_item.cost};
                if (r_cx == r_x1 - 1'b1 && r_cy == r_y1 - 1'b1) begin
                    n_state = ST_EMIT;
                end
            end
            ST_CLEAR: begin
                w_we = 1'b1;
                if (r_cnt == w_area - 1'b1) begin
                    n_state = ST_EMIT;
                end
            end
            ST_NB_RD: begin
                if (r_d == DIR_NW) begin
                    n_state = ST_NB_LAST;
                end
            end
            ST_NB_LAST: n_state = ST_NB_MASK;
            ST_NB_MASK: n_state = (w_okc == '0) ? ST_EMIT : ST_NB_EMIT;
            ST_NB_EMIT: begin
                if (w_free) begin
                    w_ld     = 1'b1;
                    w_ld_res = w_nb_res;
                    if (w_rest == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (w_free) begin
                    w_ld    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_dly_v) begin
            r_nb_data[r_dly_d] <= r_rdata;
        end
        if (w_ld) begin
            r_out <= w_ld_res;
        end
        r_dly_d <= r_d;
        case (r_state)
            ST_IDLE: begin
                r_item <= i_q_item;
                r_addr <= w_idx;
                r_cx   <= w_fx0;
                r_x0   <= w_fx0;
                r_x1   <= w_fx1;
                r_cy   <= w_fy0;
                r_y1   <= w_fy1;
                if (i_q_item.kind == K_CELL) begin
                    r_pend <= w_oob;
                end else begin
                    r_pend <= w_ack;
                end
            end
            ST_CELL_DO: r_pend <= w_cell_res;
            ST_FILL: begin
                if (r_cx == r_x1 - 1'b1) begin
                    r_cx <= r_x0;
                    r_cy <= r_cy + 1'b1;
                end else begin
                    r_cx <= r_cx + 1'b1;
                end
            end
            ST_NB_RD: r_nb_inb[r_d] <= w_nb_inb;
            ST_NB_MASK: begin
                r_ok   <= w_okc;
                r_pend <= w_ack;
            end
            ST_NB_EMIT: begin
                if (w_free) begin
                    r_ok <= w_rest;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= '0;
            r_d     <= '0;
            r_dly_v <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dly_v <= r_state == ST_NB_RD;
            if (r_state == ST_INIT || r_state == ST_CLEAR) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (r_state == ST_NB_RD) begin
                r_d <= r_d + 1'b1;
            end else begin
                r_d <= '0;
            end
            if (w_ld) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_out;

endmodule

`default_nettype wire

### hdl/cgn_checker.sv
// ----------------------------------------------------------------------------
// Grid cell store checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cgn_checker import cgn_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_in_bounds,
    input logic              o_walkable,
    input logic [FLAG_W-1:0] o_cell_flags,
    input logic              o_neighbour_valid,
    input logic              o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("A result was withdrawn before it was taken.");

    a_nb_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_neighbour_valid |-> o_in_bounds && o_walkable)
        else $error("A reported neighbour is not walkable.");

    a_oob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_bounds |-> !o_walkable && o_cell_flags == '0)
        else $error("An outside cell carries flags or walkability.");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_neighbour_valid |-> o_last)
        else $error("A single result lacks its last mark.");

endmodule

bind grid_cell_store_neighbor_query_core cgn_checker u_cgn_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_in_bounds       (o_in_bounds),
    .o_walkable        (o_walkable),
    .o_cell_flags      (o_cell_flags),
    .o_neighbour_valid (o_neighbour_valid),
    .o_last            (o_last)
);

`default_nettype wire
